// ----- src/tlas_pkg.sv -----
// Package for the text line assembler: sizes, command codes and control bytes.
package tlas_pkg;

   localparam int LINES      = 128;
   localparam int LINE_CHARS = 128;
   localparam int SLOTS      = LINES + 1;
   localparam int SLOT_W     = $clog2(SLOTS);
   localparam int COL_W      = $clog2(LINE_CHARS);
   localparam int TOT_W      = $clog2(LINES + 1);
   localparam int TADDR_W    = SLOT_W + COL_W;
   localparam int TEXT_DEPTH = SLOTS * LINE_CHARS;
   localparam int SUM_W      = SLOT_W + 2;

   localparam logic [7:0] CH_BS  = 8'h08;
   localparam logic [7:0] CH_LF  = 8'h0A;
   localparam logic [7:0] CH_CR  = 8'h0D;
   localparam logic [7:0] CH_DEL = 8'h7F;

   typedef enum logic [1:0] {
      CMD_BYTE    = 2'd0,
      CMD_PG_UP   = 2'd1,
      CMD_PG_DOWN = 2'd2,
      CMD_READ    = 2'd3
   } cmd_type;

   typedef struct packed {
      logic                is_read;
      logic                row_ok;
      logic                is_partial;
      logic [COL_W-1:0]    col;
      logic [COL_W-1:0]    tlen;
      logic [TOT_W-1:0]    total;
      logic [TOT_W-1:0]    scroll;
      logic [COL_W-1:0]    plen;
      logic                committed;
   } s1_type;

endpackage

// ----- src/tlas_ram.sv -----
// Simple dual-port RAM with registered read data.
module tlas_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 8,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/text_line_assembler_scrollback.sv -----
// A request passes through the read stage, then the response register, before its
// response is offered on rsp_valid.
// Throughput: one request per cycle while responses are not stalled; text and line
// length reads are registered; the partial line lives in its own ring slot.
// A stalled response holds the read stage; requests wait once both stages are full.
// Reset clears pointers, counts and scroll; memories are not cleared, since every
// read is bounded by a stored length. page_lines resets to 11.
module text_line_assembler_scrollback (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic [6:0] csr_write_data,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_command,
   input  logic [7:0] req_data_byte,
   input  logic [6:0] req_view_row,
   input  logic [6:0] req_column,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_char_out,
   output logic       rsp_row_valid,
   output logic [7:0] rsp_line_total,
   output logic [7:0] rsp_scroll_amount,
   output logic [6:0] rsp_partial_length,
   output logic       rsp_line_committed
);

   localparam int SW = tlas_pkg::SLOT_W;
   localparam int CW = tlas_pkg::COL_W;
   localparam int TW = tlas_pkg::TOT_W;
   localparam int UW = tlas_pkg::SUM_W;

   function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
      slot_inc = (s == SW'(tlas_pkg::SLOTS - 1)) ? '0 : s + SW'(1);
   endfunction

   logic [6:0]    page_ff;
   logic [SW-1:0] oldest_ff, oldest_in;
   logic [SW-1:0] pslot_ff, pslot_in;
   logic [TW-1:0] total_ff, total_in;
   logic [TW-1:0] scroll_ff, scroll_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] tlen_ff, tlen_in;

   logic                  s1_valid_ff, s1_valid_in;
   tlas_pkg::s1_type      s1_ff, s1_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_char_ff, rsp_char_in;
   logic       rsp_rv_ff, rsp_rv_in;
   logic [TW-1:0] rsp_total_ff, rsp_total_in;
   logic [TW-1:0] rsp_scroll_ff, rsp_scroll_in;
   logic [CW-1:0] rsp_plen_ff, rsp_plen_in;
   logic       rsp_comm_ff, rsp_comm_in;

   logic req_fire, s1_move;
   tlas_pkg::cmd_type cmd;

   logic [TW-1:0] page_w, end_w, start_w, cnt_w;
   logic [UW-1:0] sum0, sum1, sum2;
   logic [SW-1:0] rd_slot;
   logic          do_commit;
   logic [SW-1:0] slot_base;
   logic [CW-1:0] cnt_base, tl_base;
   logic [TW:0]   scroll_up;

   logic                          txt_we, txt_re, len_we, len_re;
   logic [tlas_pkg::TADDR_W-1:0]  txt_waddr, txt_raddr;
   logic [7:0]                    txt_rdata;
   logic [CW-1:0]                 len_rdata;

   assign s1_move  = !rsp_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || s1_move;
   assign req_fire = req_valid && req_ready;
   assign cmd      = tlas_pkg::cmd_type'(req_command);

   // visible window and slot of the requested row
   always_comb begin
      page_w  = (page_ff == 7'd0) ? TW'(1) : TW'(page_ff);
      end_w   = (scroll_ff > total_ff) ? '0 : total_ff - scroll_ff;
      start_w = (end_w > page_w) ? end_w - page_w : '0;
      cnt_w   = end_w - start_w;
      sum0    = UW'(oldest_ff) + UW'(start_w) + UW'(req_view_row);
      sum1    = (sum0 >= UW'(tlas_pkg::SLOTS)) ? sum0 - UW'(tlas_pkg::SLOTS) : sum0;
      sum2    = (sum1 >= UW'(tlas_pkg::SLOTS)) ? sum1 - UW'(tlas_pkg::SLOTS) : sum1;
      rd_slot = sum2[SW-1:0];
   end

   // request decode and state update
   always_comb begin
      oldest_in = oldest_ff;
      pslot_in  = pslot_ff;
      total_in  = total_ff;
      scroll_in = scroll_ff;
      count_in  = count_ff;
      tlen_in   = tlen_ff;
      do_commit = 1'b0;
      txt_we    = 1'b0;
      len_we    = 1'b0;
      scroll_up = (TW+1)'(scroll_ff) + (TW+1)'(page_w);

      s1_in            = s1_ff;
      s1_in.is_read    = 1'b0;
      s1_in.row_ok     = 1'b0;
      s1_in.is_partial = 1'b0;
      s1_in.col        = req_column;
      s1_in.tlen       = tlen_ff;

      if (req_fire) begin
         unique case (cmd)
            tlas_pkg::CMD_BYTE: begin
               priority if (req_data_byte == tlas_pkg::CH_CR) begin
               end else if (req_data_byte == tlas_pkg::CH_LF) begin
                  do_commit = (count_ff != '0);
               end else if (req_data_byte == tlas_pkg::CH_BS ||
                            req_data_byte == tlas_pkg::CH_DEL) begin
                  if (count_ff != '0) begin
                     count_in = count_ff - CW'(1);
                     if (tlen_ff > count_in) begin
                        tlen_in = count_in;
                     end
                  end
               end else begin
                  do_commit = (count_ff >= CW'(tlas_pkg::LINE_CHARS - 1));
                  txt_we    = 1'b1;
               end
            end
            tlas_pkg::CMD_PG_UP: begin
               scroll_in = (scroll_up > (TW+1)'(total_ff)) ? total_ff : scroll_up[TW-1:0];
            end
            tlas_pkg::CMD_PG_DOWN: begin
               scroll_in = (scroll_ff > page_w) ? scroll_ff - page_w : '0;
            end
            tlas_pkg::CMD_READ: begin
               s1_in.is_read = 1'b1;
               if (TW'(req_view_row) < cnt_w) begin
                  s1_in.row_ok = 1'b1;
               end else if (TW'(req_view_row) == cnt_w) begin
                  s1_in.row_ok     = 1'b1;
                  s1_in.is_partial = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end

      slot_base = do_commit ? slot_inc(pslot_ff) : pslot_ff;
      cnt_base  = do_commit ? '0 : count_ff;
      tl_base   = do_commit ? '0 : tlen_ff;

      if (do_commit) begin
         len_we   = 1'b1;
         pslot_in = slot_base;
         count_in = '0;
         tlen_in  = '0;
         if (total_ff < TW'(tlas_pkg::LINES)) begin
            total_in = total_ff + TW'(1);
         end else begin
            oldest_in = slot_inc(oldest_ff);
         end
      end

      if (txt_we) begin
         count_in = cnt_base + CW'(1);
         tlen_in  = (tl_base == cnt_base && req_data_byte != 8'd0) ?
                    tl_base + CW'(1) : tl_base;
      end

      txt_waddr = {slot_base, cnt_base};

      s1_in.total     = total_in;
      s1_in.scroll    = scroll_in;
      s1_in.plen      = count_in;
      s1_in.committed = do_commit;

      s1_valid_in = req_fire ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
   end

   assign txt_re    = req_fire;
   assign len_re    = req_fire;
   assign txt_raddr = {(s1_in.is_partial ? pslot_ff : rd_slot), req_column};

   tlas_ram #(
      .DEPTH(tlas_pkg::TEXT_DEPTH),
      .WIDTH(8)
   ) u_text_ram (
      .clock   (clock),
      .wr_en   (txt_we),
      .wr_addr (txt_waddr),
      .wr_data (req_data_byte),
      .rd_en   (txt_re),
      .rd_addr (txt_raddr),
      .rd_data (txt_rdata)
   );

   tlas_ram #(
      .DEPTH(tlas_pkg::SLOTS),
      .WIDTH(CW)
   ) u_len_ram (
      .clock   (clock),
      .wr_en   (len_we),
      .wr_addr (pslot_ff),
      .wr_data (tlen_ff),
      .rd_en   (len_re),
      .rd_addr (rd_slot),
      .rd_data (len_rdata)
   );

   // response stage
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_char_in   = rsp_char_ff;
      rsp_rv_in     = rsp_rv_ff;
      rsp_total_in  = rsp_total_ff;
      rsp_scroll_in = rsp_scroll_ff;
      rsp_plen_in   = rsp_plen_ff;
      rsp_comm_in   = rsp_comm_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (s1_valid_ff && s1_move) begin
         rsp_valid_in  = 1'b1;
         rsp_rv_in     = s1_ff.is_read && s1_ff.row_ok;
         rsp_char_in   = 8'd0;
         if (s1_ff.is_read && s1_ff.row_ok) begin
            if (s1_ff.is_partial) begin
               rsp_char_in = (s1_ff.col < s1_ff.tlen) ? txt_rdata : 8'd0;
            end else begin
               rsp_char_in = (s1_ff.col < len_rdata) ? txt_rdata : 8'd0;
            end
         end
         rsp_total_in  = s1_ff.total;
         rsp_scroll_in = s1_ff.scroll;
         rsp_plen_in   = s1_ff.plen;
         rsp_comm_in   = s1_ff.committed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         page_ff      <= 7'd11;
         oldest_ff    <= '0;
         pslot_ff     <= '0;
         total_ff     <= '0;
         scroll_ff    <= '0;
         count_ff     <= '0;
         tlen_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            page_ff <= csr_write_data;
         end
         oldest_ff    <= oldest_in;
         pslot_ff     <= pslot_in;
         total_ff     <= total_in;
         scroll_ff    <= scroll_in;
         count_ff     <= count_in;
         tlen_ff      <= tlen_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_ff <= s1_in;
      end
      rsp_char_ff   <= rsp_char_in;
      rsp_rv_ff     <= rsp_rv_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_scroll_ff <= rsp_scroll_in;
      rsp_plen_ff   <= rsp_plen_in;
      rsp_comm_ff   <= rsp_comm_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_char_out       = rsp_char_ff;
   assign rsp_row_valid      = rsp_rv_ff;
   assign rsp_line_total     = 8'(rsp_total_ff);
   assign rsp_scroll_amount  = 8'(rsp_scroll_ff);
   assign rsp_partial_length = 7'(rsp_plen_ff);
   assign rsp_line_committed = rsp_comm_ff;

   a_scroll_bound: assert property (@(posedge clock) disable iff (reset)
      scroll_ff <= total_ff) else $error("scroll offset above line count");

   a_tlen_bound: assert property (@(posedge clock) disable iff (reset)
      tlen_ff <= count_ff) else $error("text length above partial count");

   a_commit_resets: assert property (@(posedge clock) disable iff (reset)
      do_commit |=> (count_ff <= CW'(1) && tlen_ff <= CW'(1)))
      else $error("partial line not restarted after commit");

   a_slot_ring: assert property (@(posedge clock) disable iff (reset)
      total_ff <= TW'(tlas_pkg::LINES) && pslot_ff < SW'(tlas_pkg::SLOTS) &&
      oldest_ff < SW'(tlas_pkg::SLOTS)) else $error("ring pointer out of range");

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the terminal line assembler with scrollback.
`timescale 1ns / 1ps

module tb;

   typedef struct packed {
      logic [7:0] ch;
      logic       row_ok;
      logic [7:0] total;
      logic [7:0] scroll;
      logic [6:0] plen;
      logic       committed;
   } term_result_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_write_enable = 1'b0;
   logic [6:0] csr_write_data = '0;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [1:0] req_command = tlas_pkg::CMD_BYTE;
   logic [7:0] req_data_byte = '0;
   logic [6:0] req_view_row = '0;
   logic [6:0] req_column = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_char_out;
   logic       rsp_row_valid;
   logic [7:0] rsp_line_total;
   logic [7:0] rsp_scroll_amount;
   logic [6:0] rsp_partial_length;
   logic       rsp_line_committed;

   // predicted terminal state
   bit [7:0]    line_text [tlas_pkg::LINES][tlas_pkg::LINE_CHARS];
   int unsigned line_len [tlas_pkg::LINES];
   int unsigned oldest_idx = 0;
   int unsigned lines_held = 0;
   int unsigned scroll_off = 0;
   bit [7:0]    partial_buf [tlas_pkg::LINE_CHARS];
   int unsigned partial_cnt = 0;
   bit [6:0]    page_cfg = 7'd11;

   term_result_type pending_results[$];
   int unsigned  failures = 0;
   int unsigned  send_idle_pct = 0;
   int unsigned  recv_idle_pct = 0;
   int unsigned  hold_request = 0;
   int unsigned  hold_left = 0;

   text_line_assembler_scrollback uut (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_command(req_command),
      .req_data_byte(req_data_byte),
      .req_view_row(req_view_row),
      .req_column(req_column),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_char_out(rsp_char_out),
      .rsp_row_valid(rsp_row_valid),
      .rsp_line_total(rsp_line_total),
      .rsp_scroll_amount(rsp_scroll_amount),
      .rsp_partial_length(rsp_partial_length),
      .rsp_line_committed(rsp_line_committed)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int unsigned page_step();
      return (page_cfg == 0) ? 1 : page_cfg;
   endfunction

   function automatic void window_rows(output int unsigned first, output int unsigned rows);
      int unsigned last;
      last = (scroll_off > lines_held) ? 0 : lines_held - scroll_off;
      first = (last > page_step()) ? last - page_step() : 0;
      rows = last - first;
   endfunction

   function automatic int unsigned partial_row();
      int unsigned first, rows;
      window_rows(first, rows);
      return rows;
   endfunction

   function automatic bit commit_line();
      int unsigned slot, n;
      if (partial_cnt == 0) return 1'b0;
      if (lines_held < tlas_pkg::LINES) begin
         slot = (oldest_idx + lines_held) % tlas_pkg::LINES;
         lines_held++;
      end else begin
         slot = oldest_idx;
         oldest_idx = (oldest_idx + 1) % tlas_pkg::LINES;
      end
      n = 0;
      while (n < partial_cnt && partial_buf[n] != 8'h00) n++;
      for (int i = 0; i < n; i++) line_text[slot][i] = partial_buf[i];
      line_len[slot] = n;
      partial_cnt = 0;
      return 1'b1;
   endfunction

   function automatic term_result_type step_terminal(tlas_pkg::cmd_type cmd, bit [7:0] b,
                                                     bit [6:0] r, bit [6:0] c);
      term_result_type res;
      int unsigned first, rows, slot;
      bit hit_zero;
      res = '0;
      case (cmd)
         tlas_pkg::CMD_BYTE: begin
            case (b)
               tlas_pkg::CH_CR: ;
               tlas_pkg::CH_LF: res.committed = commit_line();
               tlas_pkg::CH_BS, tlas_pkg::CH_DEL: begin
                  if (partial_cnt > 0) partial_cnt--;
               end
               default: begin
                  if (partial_cnt >= tlas_pkg::LINE_CHARS - 1) res.committed = commit_line();
                  partial_buf[partial_cnt] = b;
                  partial_cnt++;
               end
            endcase
         end
         tlas_pkg::CMD_PG_UP: begin
            scroll_off += page_step();
            if (scroll_off > lines_held) scroll_off = lines_held;
         end
         tlas_pkg::CMD_PG_DOWN: begin
            scroll_off = (scroll_off > page_step()) ? scroll_off - page_step() : 0;
         end
         default: begin
            window_rows(first, rows);
            if (r < rows) begin
               slot = (oldest_idx + first + r) % tlas_pkg::LINES;
               res.row_ok = 1'b1;
               if (c < line_len[slot]) res.ch = line_text[slot][c];
            end else if (r == rows) begin
               res.row_ok = 1'b1;
               if (c < partial_cnt) begin
                  hit_zero = 1'b0;
                  for (int i = 0; i <= c; i++) begin
                     if (partial_buf[i] == 8'h00) hit_zero = 1'b1;
                  end
                  if (!hit_zero) res.ch = partial_buf[c];
               end
            end
         end
      endcase
      res.total = 8'(lines_held);
      res.scroll = 8'(scroll_off);
      res.plen = 7'(partial_cnt);
      return res;
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endfunction

   always @(posedge clock) begin
      term_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("response with no request outstanding");
            failures++;
         end else begin
            want = pending_results.pop_front();
            check_field("char_out", want.ch, rsp_char_out);
            check_field("row_valid", want.row_ok, rsp_row_valid);
            check_field("line_total", want.total, rsp_line_total);
            check_field("scroll_amount", want.scroll, rsp_scroll_amount);
            check_field("partial_length", want.plen, rsp_partial_length);
            check_field("line_committed", want.committed, rsp_line_committed);
         end
      end
   end

   // response side: random stalls plus an optional long hold-off
   always @(posedge clock) begin
      if (hold_request != 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic send_request(input tlas_pkg::cmd_type cmd, input bit [7:0] b = 8'h00,
                               input bit [6:0] r = '0, input bit [6:0] c = '0);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_command   <= cmd;
      req_data_byte <= b;
      req_view_row  <= r;
      req_column    <= c;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_results.push_back(step_terminal(cmd, b, r, c));
   endtask

   task automatic send_byte(input bit [7:0] b);
      send_request(tlas_pkg::CMD_BYTE, b, 7'($urandom_range(127)), 7'($urandom_range(127)));
   endtask

   task automatic read_cell(input int unsigned r, input int unsigned c);
      send_request(tlas_pkg::CMD_READ, 8'($urandom_range(255)), 7'(r), 7'(c));
   endtask

   task automatic drain_results();
      int unsigned waited;
      waited = 0;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_page_lines(input bit [6:0] v);
      drain_results();
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      page_cfg = v;
   endtask

   task automatic random_request();
      int unsigned pick, rows;
      bit [7:0] b;
      bit [6:0] r, c;
      tlas_pkg::cmd_type cmd;
      pick = $urandom_range(99);
      b = 8'($urandom_range(255));
      r = 7'($urandom_range(127));
      c = 7'($urandom_range(127));
      cmd = tlas_pkg::CMD_BYTE;
      if (pick < 44) b = 8'($urandom_range(8'h7e, 8'h20));
      else if (pick < 52) b = tlas_pkg::CH_LF;
      else if (pick < 55) b = tlas_pkg::CH_CR;
      else if (pick < 59) b = ($urandom_range(1) != 0) ? tlas_pkg::CH_BS : tlas_pkg::CH_DEL;
      else if (pick < 64) b = 8'($urandom_range(255));
      else if (pick < 68) cmd = tlas_pkg::CMD_PG_UP;
      else if (pick < 72) cmd = tlas_pkg::CMD_PG_DOWN;
      else begin
         cmd = tlas_pkg::CMD_READ;
         rows = partial_row();
         if ($urandom_range(99) < 80) begin
            r = 7'($urandom_range((rows + 1 > 127) ? 127 : rows + 1));
         end
         if ($urandom_range(99) < 70) c = 7'($urandom_range(15));
      end
      send_request(cmd, b, r, c);
   endtask

   task automatic test_basic_editing();
      read_cell(0, 0);
      read_cell(1, 0);
      send_byte(8'h48);
      send_byte(8'hFF);
      send_byte(tlas_pkg::CH_CR);
      send_byte(tlas_pkg::CH_BS);
      send_byte(tlas_pkg::CH_DEL);
      send_byte(tlas_pkg::CH_DEL);
      send_byte(tlas_pkg::CH_LF);
      send_byte("O");
      send_byte("K");
      send_byte(8'h00);
      send_byte("Z");
      read_cell(0, 1);
      read_cell(0, 2);
      read_cell(0, 3);
      send_byte(tlas_pkg::CH_LF);
      send_byte(8'h00);
      send_byte(tlas_pkg::CH_LF);
      read_cell(0, 1);
      read_cell(1, 0);
      read_cell(2, 0);
      read_cell(127, 127);
      send_request(tlas_pkg::CMD_PG_UP);
      read_cell(0, 0);
      send_request(tlas_pkg::CMD_PG_DOWN);
      send_request(tlas_pkg::CMD_PG_DOWN);
   endtask

   task automatic test_line_wrap();
      write_page_lines(7'd127);
      send_request(tlas_pkg::CMD_PG_DOWN);
      send_request(tlas_pkg::CMD_PG_DOWN);
      send_byte(tlas_pkg::CH_LF);
      repeat (tlas_pkg::LINE_CHARS - 1) send_byte(8'($urandom_range(8'h7e, 8'h21)));
      read_cell(partial_row(), tlas_pkg::LINE_CHARS - 2);
      read_cell(partial_row(), tlas_pkg::LINE_CHARS - 1);
      send_byte(8'h41);
      read_cell(partial_row() - 1, tlas_pkg::LINE_CHARS - 2);
      read_cell(partial_row() - 1, 0);
      read_cell(partial_row(), 0);
      send_byte(tlas_pkg::CH_BS);
      send_byte(tlas_pkg::CH_BS);
      read_cell(partial_row(), 0);
   endtask

   task automatic test_random_stream(input int unsigned n, input bit [6:0] page,
                                     input int unsigned send_pct, input int unsigned recv_pct);
      write_page_lines(page);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      repeat (n) random_request();
   endtask

   task automatic test_scrollback_limit();
      write_page_lines(7'd1);
      for (int i = 0; i < tlas_pkg::LINES + 8; i++) begin
         send_byte(8'(8'h41 + (i % 26)));
         send_byte(8'(8'h30 + (i % 10)));
         send_byte(tlas_pkg::CH_LF);
      end
      read_cell(0, 0);
      read_cell(0, 1);
      read_cell(1, 0);
      repeat (3) send_request(tlas_pkg::CMD_PG_UP);
      read_cell(0, 1);
      write_page_lines(7'd127);
      send_request(tlas_pkg::CMD_PG_UP);
      send_request(tlas_pkg::CMD_PG_UP);
      read_cell(0, 0);
      read_cell(1, 0);
      send_request(tlas_pkg::CMD_PG_DOWN);
      read_cell(0, 0);
      send_request(tlas_pkg::CMD_PG_DOWN);
      read_cell(0, 0);
      read_cell(126, 1);
      read_cell(127, 0);
      read_cell(127, 127);
   endtask

   task automatic test_output_stall();
      drain_results();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_request = 400;
      repeat (120) random_request();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 18;
      recv_idle_pct = 55;
      test_basic_editing();
      test_line_wrap();
      test_random_stream(200, 7'd1, 18, 55);
      test_random_stream(200, 7'd127, 18, 55);
      test_random_stream(200, 7'd0, 55, 18);
      test_random_stream(200, 7'd5, 55, 18);
      test_random_stream(200, 7'($urandom_range(126, 2)), 0, 0);
      test_random_stream(200, 7'd11, 0, 0);
      test_scrollback_limit();
      test_output_stall();
      drain_results();
      if (pending_results.size() != 0) begin
         $error("%0d responses never arrived", pending_results.size());
         failures++;
      end
      if (failures == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
